// ===== design/impfd_pkg.sv =====
package impfd_pkg;

    localparam int DFT_W  = 16;
    localparam int CAL_W  = 32;
    localparam int PROD_W = 56;
    localparam int IMP_W  = 40;
    localparam int CNT_W  = 6;

    localparam logic [CAL_W-1:0]  CAL_RESET = 32'd256;
    localparam logic [PROD_W-1:0] PROD_MAX  = {PROD_W{1'b1}};
    localparam logic [IMP_W-1:0]  IMP_MAX   = {IMP_W{1'b1}};

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOCAL = 2'd1,
        ST_ZERO  = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef enum logic {
        REQ_CAL  = 1'b0,
        REQ_MEAS = 1'b1
    } req_t;

    // top -> engine control
    typedef struct packed {
        logic start;
        req_t req_type;
        logic calibrated;
        logic out_free;
    } eng_cmd_t;

    // engine -> top status
    typedef struct packed {
        logic    ready;
        logic    done;
        logic    cal_we;
        status_t status;
    } eng_rsp_t;

endpackage

// ===== design/impfd_alu.sv =====
module impfd_alu #(
    parameter int W = 26
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] res,
    output logic         carry
);

    logic [W-1:0] b_op;

    // for a subtract, carry out high means a >= b
    assign b_op = sub ? ~b : b;
    assign {carry, res} = (W+1)'(a) + (W+1)'(b_op) + (W+1)'(sub);

endmodule

// ===== design/impfd_engine.sv =====
module impfd_engine #(
    parameter int MAG_FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  impfd_pkg::eng_cmd_t               cmd,
    input  logic signed [impfd_pkg::DFT_W-1:0] real_part,
    input  logic signed [impfd_pkg::DFT_W-1:0] imag_part,
    input  logic [impfd_pkg::CAL_W-1:0]       cal_impedance,
    input  logic [impfd_pkg::PROD_W-1:0]      cal_product,
    output impfd_pkg::eng_rsp_t               rsp,
    output logic [impfd_pkg::IMP_W-1:0]       impedance,
    output logic [impfd_pkg::PROD_W-1:0]      cal_product_new
);

    localparam int DFT_W  = impfd_pkg::DFT_W;
    localparam int CAL_W  = impfd_pkg::CAL_W;
    localparam int PROD_W = impfd_pkg::PROD_W;
    localparam int IMP_W  = impfd_pkg::IMP_W;
    localparam int CNT_W  = impfd_pkg::CNT_W;
    localparam int MAG_W  = DFT_W + MAG_FRAC_BITS;
    localparam int AW     = MAG_W + 2;
    localparam int XW     = 2 * MAG_W;
    localparam int PW     = MAG_W + CAL_W;
    localparam int SQ_W   = 2 * DFT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ0,
        S_SQ1,
        S_SQRT,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    impfd_pkg::req_t        req_reg, req_next;
    impfd_pkg::status_t     status_reg, status_next;
    logic                   cal_we_reg, cal_we_next;
    logic [DFT_W-1:0]       re_reg, re_next;
    logic [DFT_W-1:0]       im_reg, im_next;
    logic [SQ_W-1:0]        sum_reg, sum_next;
    logic [XW-1:0]          x_reg, x_next;
    logic [AW-1:0]          rem_reg, rem_next;
    logic [MAG_W-1:0]       root_reg, root_next;
    logic [PW-1:0]          p_reg, p_next;
    logic [PROD_W-1:0]      quo_reg, quo_next;
    logic [IMP_W-1:0]       imp_reg, imp_next;

    logic [DFT_W-1:0]       re_abs, im_abs, sq_in;
    logic [SQ_W-1:0]        sq;
    logic [AW-1:0]          alu_a, alu_b, alu_res;
    logic                   alu_sub, alu_carry;
    logic [AW-1:0]          sqrt_sh, div_sh;
    logic [MAG_W-1:0]       mul_hi;
    logic [PW-1:0]          p_step;
    logic [PROD_W-1:0]      quo_step;
    logic [63:0]            prod64;

    assign re_abs = real_part[DFT_W-1] ? DFT_W'(~real_part + 1'b1) : DFT_W'(real_part);
    assign im_abs = imag_part[DFT_W-1] ? DFT_W'(~imag_part + 1'b1) : DFT_W'(imag_part);

    assign sq_in = (state_reg == S_SQ0) ? re_reg : im_reg;
    assign sq    = sq_in * sq_in;

    // operand layouts for the three iterative phases
    assign sqrt_sh = {rem_reg[AW-3:0], x_reg[XW-1 -: 2]};
    assign mul_hi  = p_reg[PW-1:CAL_W];
    assign div_sh  = AW'({rem_reg[MAG_W-1:0], quo_reg[PROD_W-1]});

    always_comb
    begin
        case (state_reg)
            S_SQRT:
            begin
                alu_a   = sqrt_sh;
                alu_b   = {root_reg, 2'b01};
                alu_sub = 1'b1;
            end
            S_MUL:
            begin
                alu_a   = AW'(mul_hi);
                alu_b   = AW'(root_reg);
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a   = div_sh;
                alu_b   = AW'(root_reg);
                alu_sub = 1'b1;
            end
        endcase
    end

    impfd_alu #(
        .W(AW)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .res   (alu_res),
        .carry (alu_carry)
    );

    assign p_step = p_reg[0] ? {alu_res[MAG_W:0], p_reg[CAL_W-1:1]}
                             : {1'b0, mul_hi, p_reg[CAL_W-1:1]};
    assign prod64   = 64'(p_step);
    assign quo_step = {quo_reg[PROD_W-2:0], alu_carry};

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        req_next    = req_reg;
        status_next = status_reg;
        cal_we_next = cal_we_reg;
        re_next     = re_reg;
        im_next     = im_reg;
        sum_next    = sum_reg;
        x_next      = x_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        p_next      = p_reg;
        quo_next    = quo_reg;
        imp_next    = imp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    req_next    = cmd.req_type;
                    re_next     = re_abs;
                    im_next     = im_abs;
                    status_next = impfd_pkg::ST_OK;
                    cal_we_next = 1'b0;
                    imp_next    = '0;
                    if (cmd.req_type == impfd_pkg::REQ_MEAS && !cmd.calibrated)
                    begin
                        status_next = impfd_pkg::ST_NOCAL;
                        state_next  = S_DONE;
                    end
                    else if (re_abs == '0 && im_abs == '0)
                    begin
                        status_next = impfd_pkg::ST_ZERO;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SQ0;
                    end
                end
            end
            S_SQ0:
            begin
                sum_next   = sq;
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                sum_next   = sum_reg + sq;
                x_next     = XW'(sum_next) << (2 * MAG_FRAC_BITS);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = CNT_W'(MAG_W - 1);
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                // one root bit per cycle, restoring
                x_next = x_reg << 2;
                if (alu_carry)
                begin
                    rem_next  = alu_res;
                    root_next = {root_reg[MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = sqrt_sh;
                    root_next = {root_reg[MAG_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    rem_next = '0;
                    if (req_reg == impfd_pkg::REQ_CAL)
                    begin
                        p_next     = PW'(cal_impedance);
                        cnt_next   = CNT_W'(CAL_W - 1);
                        state_next = S_MUL;
                    end
                    else
                    begin
                        quo_next   = cal_product;
                        cnt_next   = CNT_W'(PROD_W - 1);
                        state_next = S_DIV;
                    end
                end
            end
            S_MUL:
            begin
                p_next   = p_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    quo_next    = (|prod64[63:PROD_W]) ? impfd_pkg::PROD_MAX
                                                       : prod64[PROD_W-1:0];
                    cal_we_next = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DIV:
            begin
                rem_next = alu_carry ? alu_res : div_sh;
                quo_next = quo_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (|quo_step[PROD_W-1:IMP_W])
                    begin
                        imp_next    = impfd_pkg::IMP_MAX;
                        status_next = impfd_pkg::ST_SAT;
                    end
                    else
                    begin
                        imp_next = quo_step[IMP_W-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (cmd.out_free)
                begin
                    cal_we_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            cal_we_reg <= 1'b0;
            status_reg <= impfd_pkg::ST_OK;
            req_reg    <= impfd_pkg::REQ_CAL;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            cal_we_reg <= cal_we_next;
            status_reg <= status_next;
            req_reg    <= req_next;
            re_reg     <= re_next;
            im_reg     <= im_next;
            sum_reg    <= sum_next;
            x_reg      <= x_next;
            rem_reg    <= rem_next;
            root_reg   <= root_next;
            p_reg      <= p_next;
            quo_reg    <= quo_next;
            imp_reg    <= imp_next;
        end
    end

    assign rsp.ready       = (state_reg == S_IDLE);
    assign rsp.done        = (state_reg == S_DONE);
    assign rsp.cal_we      = cal_we_reg;
    assign rsp.status      = status_reg;
    assign impedance       = imp_reg;
    assign cal_product_new = quo_reg;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> state_reg == S_IDLE)
        else $error("start outside idle");

    a_cal_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done && rsp.cal_we |-> status_reg == impfd_pkg::ST_OK && root_reg != '0)
        else $error("calibration update with bad status or zero magnitude");

    a_cal_only_calreq: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done && rsp.cal_we |-> req_reg == impfd_pkg::REQ_CAL)
        else $error("calibration update on a measure request");
`endif

endmodule

// ===== design/impedance_from_dft_calibrated_top.sv =====
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       req_type, real_part, imag_part
// out       output     out_valid / out_ready     impedance, status
// cfg       input      cfg_wr_en (no wait)       cfg_wr_data (cal_impedance)
//
// after the input transfer the squares are summed, then the one shared add/subtract unit
// runs the square root and then a shift-add multiply for calibrate or a restoring divide
// for measure, one bit a cycle, before the result goes to the output register;
// not-calibrated and zero-input items go straight to the done state
// in_ready rises together with the registered result, so no new item is taken before
// that; a result still held in a full output register keeps in_ready low
// rst_n clears control, the calibration state and sets cal_impedance to 256
module impedance_from_dft_calibrated_top #(
    parameter int MAG_FRAC_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic signed [impfd_pkg::DFT_W-1:0] real_part,
    input  logic signed [impfd_pkg::DFT_W-1:0] imag_part,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [impfd_pkg::IMP_W-1:0]        impedance,
    output logic [1:0]                         status,
    input  logic                               cfg_wr_en,
    input  logic [impfd_pkg::CAL_W-1:0]        cfg_wr_data
);

    impfd_pkg::eng_cmd_t             eng_cmd;
    impfd_pkg::eng_rsp_t             eng_rsp;
    logic [impfd_pkg::IMP_W-1:0]     eng_imp;
    logic [impfd_pkg::PROD_W-1:0]    eng_prod;

    logic [impfd_pkg::CAL_W-1:0]     cal_impedance_reg;
    logic [impfd_pkg::PROD_W-1:0]    cal_product_reg;
    logic                            calibrated_reg;
    logic                            out_valid_reg;
    logic [impfd_pkg::IMP_W-1:0]     impedance_reg;
    impfd_pkg::status_t              status_reg;

    logic                            in_xfer;
    logic                            out_free;
    logic                            take;

    assign in_ready = eng_rsp.ready;
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign take     = eng_rsp.done && out_free;

    assign eng_cmd.start      = in_xfer;
    assign eng_cmd.req_type   = impfd_pkg::req_t'(req_type);
    assign eng_cmd.calibrated = calibrated_reg;
    assign eng_cmd.out_free   = out_free;

    impfd_engine #(
        .MAG_FRAC_BITS(MAG_FRAC_BITS)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (eng_cmd),
        .real_part       (real_part),
        .imag_part       (imag_part),
        .cal_impedance   (cal_impedance_reg),
        .cal_product     (cal_product_reg),
        .rsp             (eng_rsp),
        .impedance       (eng_imp),
        .cal_product_new (eng_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_impedance_reg <= impfd_pkg::CAL_RESET;
            cal_product_reg   <= '0;
            calibrated_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            status_reg        <= impfd_pkg::ST_OK;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cal_impedance_reg <= cfg_wr_data;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
                impedance_reg <= eng_imp;
                status_reg    <= eng_rsp.status;
                // state is committed when the result enters the output register
                if (eng_rsp.cal_we)
                begin
                    cal_product_reg <= eng_prod;
                    calibrated_reg  <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign impedance = impedance_reg;
    assign status    = status_reg;

`ifndef NO_ASSERTIONS
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == impfd_pkg::ST_SAT |-> impedance_reg == impfd_pkg::IMP_MAX)
        else $error("saturated result not at maximum");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == impfd_pkg::ST_NOCAL || status_reg == impfd_pkg::ST_ZERO)
        |-> impedance_reg == '0)
        else $error("error result with nonzero impedance");

    a_cal_commit: assert property (@(posedge clk) disable iff (!rst_n)
        take && eng_rsp.cal_we |=> calibrated_reg && cal_product_reg == $past(eng_prod))
        else $error("calibration not committed");
`endif

endmodule

// ===== verif/impfd_checker.sv =====
module impfd_checker
    import impfd_pkg::*;
#(
    parameter int MAG_FRAC_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    req_type,
    input  logic signed [DFT_W-1:0] real_part,
    input  logic signed [DFT_W-1:0] imag_part,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [IMP_W-1:0]        impedance,
    input  logic [1:0]              status,
    input  logic                    cfg_wr_en,
    input  logic [CAL_W-1:0]        cfg_wr_data,
    output int                      errors,
    output int                      pending
);

    typedef struct packed {
        logic [IMP_W-1:0] impedance;
        status_t          status;
    } reading_t;

    logic [CAL_W-1:0]  cal_ohms;
    logic [PROD_W-1:0] cal_prod;
    logic              is_calibrated;
    reading_t          readings[$];
    int                fail_count = 0;

    initial begin
        errors  = 0;
        pending = 0;
    end

    // truncated square root of (re^2 + im^2) scaled by 2^(2*MAG_FRAC_BITS)
    function automatic logic [63:0] dft_magnitude(logic [DFT_W-1:0] re, logic [DFT_W-1:0] im);
        logic [63:0] abs_re;
        logic [63:0] abs_im;
        logic [63:0] radicand;
        logic [63:0] root;
        logic [63:0] trial;
        abs_re = re[DFT_W-1] ? 64'h10000 - 64'(re) : 64'(re);
        abs_im = im[DFT_W-1] ? 64'h10000 - 64'(im) : 64'(im);
        radicand = (abs_re * abs_re + abs_im * abs_im) << (2 * MAG_FRAC_BITS);
        root = '0;
        for (int b = 30; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root;
    endfunction

    function automatic reading_t predict_reading(req_t rq, logic [DFT_W-1:0] re,
                                                 logic [DFT_W-1:0] im);
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [63:0]  quot;
        reading_t     r;
        mag = dft_magnitude(re, im);
        r.impedance = '0;
        r.status = ST_OK;
        if (rq == REQ_CAL)
        begin
            if (mag == 0)
                r.status = ST_ZERO;
            else
            begin
                prod = 128'(mag) * 128'(cal_ohms);
                cal_prod = (prod > 128'(PROD_MAX)) ? PROD_MAX : prod[PROD_W-1:0];
                is_calibrated = 1'b1;
            end
        end
        else if (!is_calibrated)
            r.status = ST_NOCAL;
        else if (mag == 0)
            r.status = ST_ZERO;
        else
        begin
            quot = 64'(cal_prod) / mag;
            if (quot > 64'(IMP_MAX))
            begin
                r.impedance = IMP_MAX;
                r.status = ST_SAT;
            end
            else
                r.impedance = quot[IMP_W-1:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            cal_ohms = CAL_RESET;
            cal_prod = '0;
            is_calibrated = 1'b0;
            readings.delete();
        end
        else
        begin
            if (cfg_wr_en)
                cal_ohms = cfg_wr_data;
            if (out_valid && out_ready)
            begin
                if (readings.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual impedance %0d status %0d",
                             $time, impedance, status);
                    fail_count++;
                end
                else
                begin
                    want = readings.pop_front();
                    if (impedance !== want.impedance)
                        $display("%0t: impedance mismatch, expected %0d, actual %0d",
                                 $time, want.impedance, impedance);
                    if (status !== want.status)
                        $display("%0t: status mismatch, expected %s, actual %0d",
                                 $time, want.status.name(), status);
                    if (impedance !== want.impedance || status !== want.status)
                        fail_count++;
                end
            end
            // output is checked first so a transfer in this cycle cannot pair with itself
            if (in_valid && in_ready)
                readings.push_back(predict_reading(req_t'(req_type), real_part, imag_part));
        end
        pending <= readings.size();
        errors <= fail_count;
    end

endmodule

// ===== verif/tb_impedance_from_dft_calibrated_top.sv =====
module tb_impedance_from_dft_calibrated_top;
    import impfd_pkg::*;

    localparam int MAG_FRAC_BITS = 8;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    req_type = REQ_CAL;
    logic signed [DFT_W-1:0] real_part = '0;
    logic signed [DFT_W-1:0] imag_part = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [IMP_W-1:0]        impedance;
    logic [1:0]              status;
    logic                    cfg_wr_en = 1'b0;
    logic [CAL_W-1:0]        cfg_wr_data = '0;
    int                      errors;
    int                      pending;
    bit                      no_gaps = 1'b0;

    impedance_from_dft_calibrated_top #(
        .MAG_FRAC_BITS(MAG_FRAC_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .real_part  (real_part),
        .imag_part  (imag_part),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .impedance  (impedance),
        .status     (status),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    impfd_checker #(
        .MAG_FRAC_BITS(MAG_FRAC_BITS)
    ) readings_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .real_part  (real_part),
        .imag_part  (imag_part),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .impedance  (impedance),
        .status     (status),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // called at a rising edge; returns at the edge where the transfer happened
    task automatic send_item(input req_t rq, input logic signed [DFT_W-1:0] re,
                             input logic signed [DFT_W-1:0] im);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= rq;
        real_part <= re;
        imag_part <= im;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_readings();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_cal_impedance(input logic [CAL_W-1:0] ohms);
        drain_readings();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ohms;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [DFT_W-1:0] rand_dft();
        logic [DFT_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = 16'h8000;
            2: v = 16'h7fff;
            3: v = 16'hffff;
            4: v = DFT_W'($urandom_range(0, 15));
            5: v = DFT_W'(-$urandom_range(1, 15));
            default: v = DFT_W'($urandom);
        endcase
        return v;
    endfunction

    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        req_t             rq;
        logic [CAL_W-1:0] ohms;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before any calibration, including a zero input and a zero-input calibrate
        send_item(REQ_MEAS, 100, 50);
        send_item(REQ_MEAS, 0, 0);
        send_item(REQ_CAL, 0, 0);
        send_item(REQ_MEAS, 3, 4);
        // default 1 ohm calibration
        send_item(REQ_CAL, 3, 4);
        send_item(REQ_MEAS, 3, 4);
        send_item(REQ_MEAS, -4, -3);
        send_item(REQ_MEAS, 0, 0);
        send_item(REQ_MEAS, 16'sh8000, 16'sh8000);
        send_item(REQ_MEAS, 16'sh7fff, 16'sh8000);
        send_item(REQ_CAL, 16'sh8000, 16'sh8000);
        // zero-input calibrate keeps the stored product
        send_item(REQ_CAL, 0, 0);
        send_item(REQ_MEAS, 0, -1);
        send_item(REQ_MEAS, 1, 0);

        // largest impedance: small measured magnitude saturates
        set_cal_impedance('1);
        send_item(REQ_CAL, 16'sh8000, 16'sh8000);
        send_item(REQ_MEAS, 0, 1);
        send_item(REQ_MEAS, 16'sh7fff, 16'sh7fff);

        // zero impedance gives a zero product and zero readings
        set_cal_impedance('0);
        send_item(REQ_CAL, 12, -5);
        send_item(REQ_MEAS, 1, 1);

        set_cal_impedance(32'd1);
        send_item(REQ_CAL, 1, 0);
        send_item(REQ_MEAS, 16'sh8000, 0);
        send_item(REQ_MEAS, 1, 0);

        for (int ph = 0; ph < 13; ph++)
        begin
            case ($urandom_range(0, 5))
                0: ohms = 32'd1;
                1: ohms = '1;
                2: ohms = $urandom;
                3: ohms = $urandom_range(1, 65535);
                4: ohms = CAL_RESET;
                default: ohms = $urandom_range(1 << 20, 1 << 28);
            endcase
            set_cal_impedance(ohms);
            no_gaps = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < 100; i++)
            begin
                rq = ($urandom_range(0, 4) == 0) ? REQ_CAL : REQ_MEAS;
                if ($urandom_range(0, 19) == 0)
                    send_item(rq, 0, 0);
                else
                    send_item(rq, rand_dft(), rand_dft());
            end
        end
        no_gaps = 1'b0;

        drain_readings();
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== impedance_from_dft_calibrated_top.f =====
design/impfd_pkg.sv
design/impfd_alu.sv
design/impfd_engine.sv
design/impedance_from_dft_calibrated_top.sv
verif/impfd_checker.sv
verif/tb_impedance_from_dft_calibrated_top.sv
